/* sv/dbgr_pkg.sv */
// ----------------------------------------------------------------------------
// dbgr_pkg: shared constants for the double-byte glyph rasterizer
// Field layout of the stream beats, glyph store size and beat kind codes.
// ----------------------------------------------------------------------------
package dbgr_pkg;

  localparam int NUM_GLYPHS  = 2350;
  localparam int MAX_CELL    = 16;
  localparam int CELL_LIM    = (MAX_CELL < 16) ? MAX_CELL : 16;

  localparam int STORE_BYTES = NUM_GLYPHS * 8;
  localparam int STORE_AW    = $clog2(STORE_BYTES);

  // glyph index range follows from the lead and trail byte ranges
  localparam int GI_W = 12;

  localparam logic [7:0] LEAD_FIRST  = 8'h80;
  localparam logic [7:0] LEAD_LAST   = 8'h98;
  localparam logic [7:0] TRAIL_FIRST = 8'hA0;

  // input beat kinds (tuser)
  localparam logic KIND_TEXT  = 1'b0;
  localparam logic KIND_STORE = 1'b1;

  // output beat kinds (tuser)
  localparam logic OUT_PASS = 1'b0;
  localparam logic OUT_ROW  = 1'b1;

  localparam int IN_DATA_W  = 56;
  localparam int OUT_DATA_W = 40;

  // output tdata field positions
  localparam int OD_CHAR_LSB = 0;
  localparam int OD_FONT_LSB = 8;
  localparam int OD_ROW_LSB  = 11;
  localparam int OD_BITS_LSB = 15;
  localparam int OD_ADV_LSB  = 31;

endpackage

/* sv/double_byte_glyph_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// double_byte_glyph_rasterizer_unit: double-byte text to glyph bitmap rows
// Holds a lead byte, forms a glyph index with the trail byte and emits one
// scaled, centered bitmap row per cell line from the internal glyph store.
// ----------------------------------------------------------------------------
// Rate: a glyph store write or a lead byte gives no beat and leaves the input
// ready. A byte that passes through gives one beat. A glyph fetches the first
// store row in ST_LOAD, then gives one row beat a cycle while the output is
// not stalled, set by the single read port of the glyph store that feeds one
// row per cycle. The input is not ready while an item is being worked. Glyph
// rows read store entries that must have been written.
module double_byte_glyph_rasterizer_unit (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic                               cfg_wdata_i,    // glyph_ready
  input  logic                               s_axis_tvalid_i,
  output logic                               s_axis_tready_o,
  // tdata from bit 0: char_code[8], font_select[3], cell_width[5],
  // cell_height[5], spacing[8], store_addr[15], store_data[8], zero pad[4]
  input  logic [dbgr_pkg::IN_DATA_W-1:0]     s_axis_tdata_i,
  input  logic                               s_axis_tuser_i, // kind
  output logic                               m_axis_tvalid_o,
  input  logic                               m_axis_tready_i,
  // tdata from bit 0: out_char[8], out_font[3], row_index[4], row_bits[16],
  // advance[8], zero pad[1]
  output logic [dbgr_pkg::OUT_DATA_W-1:0]    m_axis_tdata_o,
  output logic                               m_axis_tuser_o, // out_kind
  output logic                               m_axis_tlast_o  // last
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PASS = 2'd1;
  localparam logic [1:0] ST_LOAD = 2'd2;
  localparam logic [1:0] ST_ROW  = 2'd3;

  // j * 8 / t for j < t <= 8, by counting multiples of t
  function automatic logic [2:0] src_idx(input logic [2:0] j, input logic [3:0] t);
    logic [2:0] cnt;
    logic [6:0] rhs;
    cnt = 3'd0;
    rhs = {1'b0, j, 3'b000};
    for (int k = 1; k < 8; k++) begin
      if (7'(k) * {3'b000, t} <= rhs) begin
        cnt = cnt + 3'd1;
      end
    end
    return cnt;
  endfunction

  // input fields
  logic [7:0]            in_char;
  logic [2:0]            in_font;
  logic [4:0]            in_cw;
  logic [4:0]            in_ch;
  logic [7:0]            in_sp;
  logic [14:0]           in_addr;
  logic [7:0]            in_data;

  assign in_char = s_axis_tdata_i[7:0];
  assign in_font = s_axis_tdata_i[10:8];
  assign in_cw   = s_axis_tdata_i[15:11];
  assign in_ch   = s_axis_tdata_i[20:16];
  assign in_sp   = s_axis_tdata_i[28:21];
  assign in_addr = s_axis_tdata_i[43:29];
  assign in_data = s_axis_tdata_i[51:44];

  logic [1:0]            state_q, state_d;
  logic                  ready_q;
  logic                  lead_valid_q, lead_valid_d;
  logic [4:0]            lead_off_q, lead_off_d;

  // per item work registers
  logic [7:0]            char_q, char_d;
  logic [2:0]            font_q, font_d;
  logic [dbgr_pkg::GI_W-1:0] gi_q, gi_d;
  logic [4:0]            h_q, h_d;
  logic [3:0]            tw_q, tw_d;
  logic [3:0]            th_q, th_d;
  logic [2:0]            xo_q, xo_d;
  logic [4:0]            yo_q, yo_d;
  logic [7:0]            adv_q, adv_d;
  logic [3:0]            y_q, y_d;

  // output register
  logic                  m_valid_q, m_valid_d;
  logic [dbgr_pkg::OUT_DATA_W-1:0] m_data_q, m_data_d;
  logic                  m_user_q, m_user_d;
  logic                  m_last_q, m_last_d;

  // glyph store
  logic [7:0]            store_mem [dbgr_pkg::STORE_BYTES];
  logic [7:0]            rdata_q;
  logic                  wr_en;
  logic [dbgr_pkg::STORE_AW-1:0] rd_addr;
  logic [2:0]            rd_row;

  logic                  accept;
  logic                  slot_free;
  logic                  is_lead;
  logic                  glyph_go;
  logic [4:0]            w_c, h_c;
  logic [3:0]            tw_c, th_c;
  logic [dbgr_pkg::GI_W-1:0] gi_c;
  logic signed [9:0]     adv_s;
  logic [7:0]            adv_c;

  logic                  in_band;
  logic [7:0]            scaled;
  logic [15:0]           row_bits;
  logic                  row_last;
  logic [4:0]            y_ext;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign slot_free       = !m_valid_q || m_axis_tready_i;

  assign is_lead = (in_char >= dbgr_pkg::LEAD_FIRST) && (in_char <= dbgr_pkg::LEAD_LAST);

  // cell geometry and glyph index for the arriving byte
  always_comb begin
    w_c  = (in_cw > 5'(dbgr_pkg::CELL_LIM)) ? 5'(dbgr_pkg::CELL_LIM) : in_cw;
    h_c  = (in_ch > 5'(dbgr_pkg::CELL_LIM)) ? 5'(dbgr_pkg::CELL_LIM) : in_ch;
    tw_c = (w_c < 5'd8) ? w_c[3:0] : 4'd8;
    th_c = (h_c < 5'd8) ? h_c[3:0] : 4'd8;
    gi_c = ({7'd0, lead_off_q} << 6) + ({7'd0, lead_off_q} << 5)
         + dbgr_pkg::GI_W'(in_char - dbgr_pkg::TRAIL_FIRST);
    adv_s = $signed({6'd0, tw_c}) - $signed({{2{in_sp[7]}}, in_sp});
    if (adv_s < 10'sd1) begin
      adv_c = 8'd1;
    end else if (adv_s > 10'sd255) begin
      adv_c = 8'd255;
    end else begin
      adv_c = adv_s[7:0];
    end
    glyph_go = lead_valid_q && (in_char >= dbgr_pkg::TRAIL_FIRST) && ready_q
            && (gi_c < dbgr_pkg::GI_W'(dbgr_pkg::NUM_GLYPHS))
            && (w_c != 5'd0) && (h_c != 5'd0);
  end

  // row pixels from the registered store byte
  always_comb begin
    y_ext   = {1'b0, y_q};
    in_band = (y_ext >= yo_q) && (y_ext < yo_q + {1'b0, th_q});
    for (int x = 0; x < 8; x++) begin
      scaled[7 - x] = (4'(x) < tw_q) && rdata_q[3'd7 - src_idx(3'(x), tw_q)];
    end
    row_bits = in_band ? ({scaled, 8'd0} >> xo_q) : 16'd0;
    row_last = ({1'b0, y_q} + 5'd1 == h_q);
  end

  // sequencer
  always_comb begin
    state_d      = state_q;
    lead_valid_d = lead_valid_q;
    lead_off_d   = lead_off_q;
    char_d       = char_q;
    font_d       = font_q;
    gi_d         = gi_q;
    h_d          = h_q;
    tw_d         = tw_q;
    th_d         = th_q;
    xo_d         = xo_q;
    yo_d         = yo_q;
    adv_d        = adv_q;
    y_d          = y_q;
    m_valid_d    = m_valid_q && !m_axis_tready_i;
    m_data_d     = m_data_q;
    m_user_d     = m_user_q;
    m_last_d     = m_last_q;
    wr_en        = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          priority if (s_axis_tuser_i == dbgr_pkg::KIND_STORE) begin
            wr_en = ({17'd0, in_addr} < 32'(dbgr_pkg::STORE_BYTES));
          end else if (is_lead) begin
            lead_valid_d = 1'b1;
            lead_off_d   = 5'(in_char - dbgr_pkg::LEAD_FIRST);
          end else begin
            lead_valid_d = 1'b0;
            char_d       = in_char;
            font_d       = in_font;
            gi_d         = gi_c;
            h_d          = h_c;
            tw_d         = tw_c;
            th_d         = th_c;
            xo_d         = 3'((w_c - {1'b0, tw_c}) >> 1);
            yo_d         = (h_c - {1'b0, th_c}) >> 1;
            adv_d        = adv_c;
            y_d          = 4'd0;
            state_d      = glyph_go ? ST_LOAD : ST_PASS;
          end
        end
      end
      ST_PASS: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_user_d  = dbgr_pkg::OUT_PASS;
          m_last_d  = 1'b1;
          m_data_d  = {32'd0, char_q};
          m_data_d[dbgr_pkg::OD_FONT_LSB +: 3] = font_q;
          state_d   = ST_IDLE;
        end
      end
      ST_LOAD: begin
        state_d = ST_ROW;
      end
      ST_ROW: begin
        if (slot_free) begin
          m_valid_d = 1'b1;
          m_user_d  = dbgr_pkg::OUT_ROW;
          m_last_d  = row_last;
          m_data_d  = {1'b0, adv_q, row_bits, y_q, font_q, 8'd0};
          if (row_last) begin
            state_d = ST_IDLE;
          end else begin
            y_d = y_q + 4'd1;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // look ahead one row so the store byte lines up with y_q
  always_comb begin
    rd_row  = src_idx(3'({1'b0, y_d} - yo_q), th_q);
    if ({1'b0, y_d} < yo_q) begin
      rd_row = 3'd0;
    end
    rd_addr = dbgr_pkg::STORE_AW'({gi_q, rd_row});
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      store_mem[dbgr_pkg::STORE_AW'(in_addr)] <= in_data;
    end
    rdata_q <= store_mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      ready_q      <= 1'b0;
      lead_valid_q <= 1'b0;
      lead_off_q   <= 5'd0;
      m_valid_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      lead_valid_q <= lead_valid_d;
      lead_off_q   <= lead_off_d;
      m_valid_q    <= m_valid_d;
      if (cfg_we_i) begin
        ready_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    char_q   <= char_d;
    font_q   <= font_d;
    gi_q     <= gi_d;
    h_q      <= h_d;
    tw_q     <= tw_d;
    th_q     <= th_d;
    xo_q     <= xo_d;
    yo_q     <= yo_d;
    adv_q    <= adv_d;
    y_q      <= y_d;
    m_data_q <= m_data_d;
    m_user_q <= m_user_d;
    m_last_q <= m_last_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;
  assign m_axis_tuser_o  = m_user_q;
  assign m_axis_tlast_o  = m_last_q;

endmodule

/* sv/dbgr_checker.sv */
// ----------------------------------------------------------------------------
// dbgr_checker: port-level checks for the double-byte glyph rasterizer
// Watches the stream ports over time and is bound to the top level.
// ----------------------------------------------------------------------------
module dbgr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            s_axis_tvalid_i,
  input logic                            s_axis_tready_o,
  input logic [dbgr_pkg::IN_DATA_W-1:0]  s_axis_tdata_i,
  input logic                            s_axis_tuser_i,
  input logic                            m_axis_tvalid_o,
  input logic                            m_axis_tready_i,
  input logic [dbgr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o,
  input logic                            m_axis_tuser_o,
  input logic                            m_axis_tlast_o
);

  logic is_lead_in;

  assign is_lead_in = (s_axis_tdata_i[7:0] >= dbgr_pkg::LEAD_FIRST)
                   && (s_axis_tdata_i[7:0] <= dbgr_pkg::LEAD_LAST);

  // a stalled beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=>
      m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
      && $stable(m_axis_tlast_o))
    else $error("output beat changed while stalled");

  // pass-through beat is a single last beat with empty row fields
  a_pass_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == dbgr_pkg::OUT_PASS) |->
      m_axis_tlast_o && (m_axis_tdata_o[dbgr_pkg::OUT_DATA_W-1:dbgr_pkg::OD_ROW_LSB] == '0))
    else $error("pass-through beat carries row data");

  // glyph rows carry no character and a nonzero advance
  a_row_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (m_axis_tuser_o == dbgr_pkg::OUT_ROW) |->
      (m_axis_tdata_o[7:0] == 8'd0) && (m_axis_tdata_o[38:31] != 8'd0))
    else $error("glyph row beat malformed");

  // store writes and lead bytes produce nothing, so the input stays open
  a_quiet_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o
      && ((s_axis_tuser_i == dbgr_pkg::KIND_STORE) || is_lead_in) |=> s_axis_tready_o)
    else $error("input stalled after a store write or lead byte");

endmodule

bind double_byte_glyph_rasterizer_unit dbgr_checker u_dbgr_checker (.*);

/* tb/sv/tb_double_byte_glyph_rasterizer_unit.sv */
// ----------------------------------------------------------------------------
// tb_double_byte_glyph_rasterizer_unit: stream-level check of the rasterizer
// Loads glyphs into the store, sends lead/trail byte pairs and stray bytes,
// and predicts every pass-through or bitmap row beat. Output beats are
// compared field by field, in order, under random source gaps and sink stalls.
// ----------------------------------------------------------------------------
module tb_double_byte_glyph_rasterizer_unit;

  localparam int TRAIL_SPAN    = 96;
  localparam int SETTLE_CYCLES = 24;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [2:0]  font;
    logic [4:0]  cell_w;
    logic [4:0]  cell_h;
    logic [7:0]  spacing;
    logic [14:0] addr;
    logic [7:0]  data;
  } src_beat_t;

  typedef struct packed {
    logic        kind;
    logic [7:0]  char_code;
    logic [2:0]  font;
    logic [3:0]  row;
    logic [15:0] bits;
    logic [7:0]  advance;
    logic        last;
  } row_beat_t;

  logic                            clk_i           = 1'b0;
  logic                            rst_ni          = 1'b0;
  logic                            cfg_we_i        = 1'b0;
  logic                            cfg_wdata_i     = 1'b0;
  logic                            s_axis_tvalid_i = 1'b0;
  logic                            s_axis_tready_o;
  logic [dbgr_pkg::IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                            s_axis_tuser_i  = 1'b0;
  logic                            m_axis_tvalid_o;
  logic                            m_axis_tready_i = 1'b0;
  logic [dbgr_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;
  logic                            m_axis_tuser_o;
  logic                            m_axis_tlast_o;

  double_byte_glyph_rasterizer_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

  src_beat_t pending_beats[$];
  row_beat_t expected_rows[$];
  int        beats_issued   = 0;
  int        beats_accepted = 0;
  int        errors         = 0;
  int        send_idle_pct  = 0;
  int        recv_stall_pct = 0;
  logic      in_taken       = 1'b0;

  // predictor copy of the block state
  logic       pred_ready      = 1'b0;
  logic       pred_lead_valid = 1'b0;
  logic [4:0] pred_lead_off   = '0;
  bit   [7:0] pred_store [dbgr_pkg::STORE_BYTES];

  // stimulus-side shadow, used to keep glyph reads on written store rows
  bit gen_ready      = 1'b0;
  bit gen_lead_valid = 1'b0;
  int gen_lead_off   = 0;
  bit gen_written [dbgr_pkg::STORE_BYTES];
  int loaded_glyphs[$];

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    #4000000;
    $display("double_byte_glyph_rasterizer_unit test failed");
    $finish;
  end

  function automatic int clamp_cell(int v);
    return (v > dbgr_pkg::CELL_LIM) ? dbgr_pkg::CELL_LIM : v;
  endfunction

  function automatic logic [dbgr_pkg::IN_DATA_W-1:0] pack_src(src_beat_t b);
    return {4'b0, b.data, b.addr, b.spacing, b.cell_h, b.cell_w, b.font, b.char_code};
  endfunction

  function automatic src_beat_t unpack_src(logic [dbgr_pkg::IN_DATA_W-1:0] d, logic k);
    src_beat_t b;
    b.kind      = k;
    b.char_code = d[7:0];
    b.font      = d[10:8];
    b.cell_w    = d[15:11];
    b.cell_h    = d[20:16];
    b.spacing   = d[28:21];
    b.addr      = d[43:29];
    b.data      = d[51:44];
    return b;
  endfunction

  // Expected beats for one accepted input beat.
  task automatic rasterize_beat(input src_beat_t b);
    int         gi, w, h, tw, th, xo, yo, adv, sy, sx;
    logic [7:0] src;
    logic [15:0] bits;
    bit         drawn;
    drawn = 1'b0;
    if (b.kind == dbgr_pkg::KIND_STORE) begin
      if (b.addr < dbgr_pkg::STORE_BYTES) pred_store[b.addr] = b.data;
      return;
    end
    if (b.char_code >= dbgr_pkg::LEAD_FIRST && b.char_code <= dbgr_pkg::LEAD_LAST) begin
      pred_lead_valid = 1'b1;
      pred_lead_off   = 5'(b.char_code - dbgr_pkg::LEAD_FIRST);
      return;
    end
    if (pred_lead_valid && b.char_code >= dbgr_pkg::TRAIL_FIRST) begin
      gi = int'(pred_lead_off) * TRAIL_SPAN + int'(b.char_code)
         - int'(dbgr_pkg::TRAIL_FIRST);
      w  = clamp_cell(int'(b.cell_w));
      h  = clamp_cell(int'(b.cell_h));
      if (pred_ready && gi < dbgr_pkg::NUM_GLYPHS && w > 0 && h > 0) begin
        tw  = (w < 8) ? w : 8;
        th  = (h < 8) ? h : 8;
        xo  = (w - tw) / 2;
        yo  = (h - th) / 2;
        adv = tw - int'($signed(b.spacing));
        if (adv < 1) adv = 1;
        if (adv > 255) adv = 255;
        for (int y = 0; y < h; y++) begin
          bits = '0;
          if (y >= yo && y < yo + th) begin
            sy  = ((y - yo) * 8) / th;
            src = pred_store[gi * 8 + sy];
            for (int x = 0; x < tw; x++) begin
              sx = (x * 8) / tw;
              if (src[7 - sx]) bits[15 - ((xo + x) % 16)] = 1'b1;
            end
          end
          expected_rows.push_back(row_beat_t'{kind: dbgr_pkg::OUT_ROW, char_code: 8'h00,
                                              font: b.font, row: 4'(y), bits: bits,
                                              advance: 8'(adv), last: (y == h - 1)});
        end
        drawn = 1'b1;
      end
    end
    pred_lead_valid = 1'b0;
    if (!drawn)
      expected_rows.push_back(row_beat_t'{kind: dbgr_pkg::OUT_PASS, char_code: b.char_code,
                                          font: b.font, row: 4'd0, bits: 16'd0,
                                          advance: 8'd0, last: 1'b1});
  endtask

  task automatic check_field(input string name, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endtask

  task automatic check_row();
    row_beat_t want;
    if (expected_rows.size() == 0) begin
      $error("result beat with nothing expected: tdata %h", m_axis_tdata_o);
      errors++;
      return;
    end
    want = expected_rows.pop_front();
    check_field("out_kind", want.kind, m_axis_tuser_o);
    check_field("out_char", want.char_code, m_axis_tdata_o[dbgr_pkg::OD_CHAR_LSB +: 8]);
    check_field("out_font", want.font, m_axis_tdata_o[dbgr_pkg::OD_FONT_LSB +: 3]);
    check_field("row_index", want.row, m_axis_tdata_o[dbgr_pkg::OD_ROW_LSB +: 4]);
    check_field("row_bits", want.bits, m_axis_tdata_o[dbgr_pkg::OD_BITS_LSB +: 16]);
    check_field("advance", want.advance, m_axis_tdata_o[dbgr_pkg::OD_ADV_LSB +: 8]);
    check_field("last", want.last, m_axis_tlast_o);
  endtask

  // Monitor: check the output beat first, then predict from the input beat.
  always @(posedge clk_i) begin
    in_taken <= s_axis_tvalid_i && s_axis_tready_o;
    if (rst_ni) begin
      if (cfg_we_i) pred_ready = cfg_wdata_i;
      if (m_axis_tvalid_o && m_axis_tready_i) check_row();
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        rasterize_beat(unpack_src(s_axis_tdata_i, s_axis_tuser_i));
        beats_accepted++;
      end
    end
  end

  // Driver: advance to the next beat once the current one is taken.
  always @(negedge clk_i) begin : drive
    src_beat_t b;
    if (rst_ni && (!s_axis_tvalid_i || in_taken)) begin
      if (pending_beats.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        b = pending_beats.pop_front();
        s_axis_tdata_i  <= pack_src(b);
        s_axis_tuser_i  <= b.kind;
        s_axis_tvalid_i <= 1'b1;
      end else begin
        s_axis_tvalid_i <= 1'b0;
      end
    end
  end

  always @(negedge clk_i) begin
    m_axis_tready_i <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  function automatic bit glyph_loaded(int gi);
    for (int r = 0; r < 8; r++)
      if (!gen_written[gi * 8 + r]) return 1'b0;
    return 1'b1;
  endfunction

  function automatic int random_cell();
    int r;
    r = $urandom_range(0, 99);
    if (r < 4) return 0;
    if (r < 10) return $urandom_range(17, 31);
    return $urandom_range(1, 16);
  endfunction

  function automatic src_beat_t random_beat();
    src_beat_t b;
    b.kind      = 1'($urandom_range(0, 1));
    b.char_code = 8'($urandom);
    b.font      = 3'($urandom);
    b.cell_w    = 5'(random_cell());
    b.cell_h    = 5'(random_cell());
    b.spacing   = 8'($urandom);
    b.addr      = 15'($urandom);
    b.data      = 8'($urandom);
    return b;
  endfunction

  function automatic src_beat_t text_beat(logic [7:0] code);
    src_beat_t b;
    b           = random_beat();
    b.kind      = dbgr_pkg::KIND_TEXT;
    b.char_code = code;
    return b;
  endfunction

  // Queue a beat; swap a trail byte that would hit unwritten store rows.
  task automatic queue_beat(input src_beat_t b);
    int gi;
    if (b.kind == dbgr_pkg::KIND_STORE) begin
      if (b.addr < dbgr_pkg::STORE_BYTES) gen_written[b.addr] = 1'b1;
    end else if (b.char_code >= dbgr_pkg::LEAD_FIRST
                 && b.char_code <= dbgr_pkg::LEAD_LAST) begin
      gen_lead_valid = 1'b1;
      gen_lead_off   = int'(b.char_code) - int'(dbgr_pkg::LEAD_FIRST);
    end else begin
      if (gen_lead_valid && b.char_code >= dbgr_pkg::TRAIL_FIRST && gen_ready &&
          clamp_cell(int'(b.cell_w)) > 0 && clamp_cell(int'(b.cell_h)) > 0) begin
        gi = gen_lead_off * TRAIL_SPAN + int'(b.char_code) - int'(dbgr_pkg::TRAIL_FIRST);
        if (gi < dbgr_pkg::NUM_GLYPHS && !glyph_loaded(gi))
          b.char_code = 8'($urandom_range(0, 8'h7F));
      end
      gen_lead_valid = 1'b0;
    end
    pending_beats.push_back(b);
    beats_issued++;
  endtask

  task automatic store_write(input int addr, input logic [7:0] data);
    src_beat_t b;
    b      = random_beat();
    b.kind = dbgr_pkg::KIND_STORE;
    b.addr = 15'(addr);
    b.data = data;
    queue_beat(b);
  endtask

  task automatic load_glyph(input int gi);
    int r;
    for (int row = 0; row < 8; row++) begin
      r = $urandom_range(0, 9);
      store_write(gi * 8 + row, (r == 0) ? 8'h00 : (r == 1) ? 8'hFF : 8'($urandom));
    end
    loaded_glyphs.push_back(gi);
  endtask

  task automatic queue_glyph(input int gi, input int cw, input int chh, input int sp);
    src_beat_t b;
    queue_beat(text_beat(8'(int'(dbgr_pkg::LEAD_FIRST) + gi / TRAIL_SPAN)));
    b         = text_beat(8'(int'(dbgr_pkg::TRAIL_FIRST) + gi % TRAIL_SPAN));
    b.cell_w  = 5'(cw);
    b.cell_h  = 5'(chh);
    b.spacing = 8'(sp);
    queue_beat(b);
  endtask

  // Hold until every queued beat is taken and every row has come out.
  task automatic drain();
    @(negedge clk_i);
    while (beats_accepted != beats_issued || expected_rows.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic set_ready(input logic v);
    @(negedge clk_i);
    cfg_we_i    = 1'b1;
    cfg_wdata_i = v;
    @(negedge clk_i);
    cfg_we_i  = 1'b0;
    gen_ready = v;
  endtask

  task automatic run_random(input int n);
    int sent, r, gi;
    src_beat_t b;
    sent = 0;
    while (sent < n) begin
      r = $urandom_range(0, 99);
      if ((r < 4 && loaded_glyphs.size() < 48) || loaded_glyphs.size() == 0) begin
        r  = $urandom_range(0, 9);
        gi = (r == 0) ? 0 : (r == 1) ? dbgr_pkg::NUM_GLYPHS - 1
                                     : $urandom_range(0, dbgr_pkg::NUM_GLYPHS - 1);
        load_glyph(gi);
        sent += 8;
      end else if (r < 60) begin
        gi = loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)];
        queue_glyph(gi, random_cell(), random_cell(), $urandom);
        sent += 2;
      end else if (r < 75) begin
        queue_beat(text_beat(8'($urandom)));
        sent += 1;
      end else if (r < 88) begin
        // broken pair: lead followed by another lead or by any byte
        queue_beat(text_beat(8'(int'(dbgr_pkg::LEAD_FIRST) + $urandom_range(0, 24))));
        if ($urandom_range(0, 1) == 0) begin
          gi = loaded_glyphs[$urandom_range(0, loaded_glyphs.size() - 1)];
          queue_glyph(gi, random_cell(), random_cell(), $urandom);
          sent += 3;
        end else begin
          queue_beat(text_beat(8'($urandom)));
          sent += 2;
        end
      end else begin
        b = random_beat();
        queue_beat(b);
        sent += 1;
      end
    end
  endtask

  initial begin : stimulus
    src_beat_t b;
    int        ready_seq [6];
    int        send_seq  [6];
    int        stall_seq [6];
    ready_seq = '{1, 1, 0, 1, 1, 0};
    send_seq  = '{0, 55, 0, 0, 36, 36};
    stall_seq = '{0, 0, 55, 55, 36, 0};
    stall_seq[5] = 36;

    repeat (6) @(negedge clk_i);
    rst_ni = 1'b1;

    // store not ready: glyph pairs pass through
    set_ready(1'b0);
    load_glyph(0);
    load_glyph(dbgr_pkg::NUM_GLYPHS - 1);
    store_write(dbgr_pkg::STORE_BYTES, 8'hA5);
    store_write(15'h7FFF, 8'h5A);
    queue_glyph(0, 8, 8, 0);
    drain();

    set_ready(1'b1);
    queue_glyph(0, 8, 8, 0);
    queue_glyph(dbgr_pkg::NUM_GLYPHS - 1, 16, 16, -128);
    queue_glyph(dbgr_pkg::NUM_GLYPHS - 1, 1, 1, 127);
    queue_glyph(0, 3, 5, 2);
    queue_glyph(0, 31, 0, 0);
    queue_glyph(0, 0, 20, 0);
    queue_glyph(0, 20, 31, -5);
    queue_glyph(dbgr_pkg::NUM_GLYPHS, 8, 8, 0);
    queue_beat(text_beat(dbgr_pkg::LEAD_LAST));
    queue_beat(text_beat(8'hFF));
    queue_beat(text_beat(dbgr_pkg::LEAD_FIRST));
    queue_beat(text_beat(8'h41));
    // newer lead replaces the older one
    queue_beat(text_beat(8'h85));
    queue_glyph(0, 8, 8, 0);
    // store write between lead and trail keeps the lead
    queue_beat(text_beat(dbgr_pkg::LEAD_FIRST));
    store_write(15'h7FFF, 8'h00);
    b        = text_beat(dbgr_pkg::TRAIL_FIRST);
    b.cell_w = 5'd8;
    b.cell_h = 5'd8;
    queue_beat(b);
    queue_beat(text_beat(8'h00));
    queue_beat(text_beat(8'h7F));
    queue_beat(text_beat(8'h99));
    queue_beat(text_beat(8'h9F));
    drain();

    for (int p = 0; p < 6; p++) begin
      send_idle_pct  = send_seq[p];
      recv_stall_pct = stall_seq[p];
      set_ready(1'(ready_seq[p]));
      run_random(35);
      drain();
      run_random(35);
      drain();
    end

    if (errors == 0) begin
      $display("double_byte_glyph_rasterizer_unit test passed");
    end else begin
      $display("double_byte_glyph_rasterizer_unit test failed");
    end
    $finish;
  end

endmodule
